/* hw/rtl/vvp_pkg.sv */
// Types, constants and arithmetic helpers for the vertex view/projection block.
`timescale 1ns / 1ps
`default_nettype none

package vvp_pkg;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind_camera;
        logic               coord_saturated;
    } pixel_t;

    localparam int FOV_UNITS    = 5;
    localparam int CORDIC_STEPS = 20;

    localparam logic signed [15:0] PITCH_LIMIT = 16'sd15646;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // register indexes
    localparam logic [2:0] REG_YAW   = 3'd0;
    localparam logic [2:0] REG_PITCH = 3'd1;
    localparam logic [2:0] REG_DIST  = 3'd2;
    localparam logic [2:0] REG_ZOOM  = 3'd3;
    localparam logic [2:0] REG_CX    = 3'd4;
    localparam logic [2:0] REG_CY    = 3'd5;
    localparam logic [2:0] REG_CZ    = 3'd6;

    // atan(2^-i) with 2^32 per turn
    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0:    r = 34'sh20000000;
                5'd1:    r = 34'sh12E4051D;
                5'd2:    r = 34'sh09FB385B;
                5'd3:    r = 34'sh051111D4;
                5'd4:    r = 34'sh028B0D43;
                5'd5:    r = 34'sh0145D7E1;
                5'd6:    r = 34'sh00A2F61E;
                5'd7:    r = 34'sh00517C55;
                5'd8:    r = 34'sh0028BE53;
                5'd9:    r = 34'sh00145F2E;
                5'd10:   r = 34'sh000A2F98;
                5'd11:   r = 34'sh000517CC;
                5'd12:   r = 34'sh00028BE6;
                5'd13:   r = 34'sh000145F3;
                5'd14:   r = 34'sh0000A2F9;
                5'd15:   r = 34'sh0000517C;
                5'd16:   r = 34'sh000028BE;
                5'd17:   r = 34'sh0000145F;
                5'd18:   r = 34'sh00000A2F;
                5'd19:   r = 34'sh00000517;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Q2.30 product back to integer scale, round half up
    function automatic logic signed [37:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] s;
        begin
            s = v + 68'sd536870912;
            return s[67:30];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        begin
            if (v > 40'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -40'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vertex_view_project.sv */
// Orbit-camera view transform and perspective projection, top level.
//
// Usage:
//   Camera registers sit on the APB port at byte address 4*index (yaw, pitch,
//   distance, zoom, centre x/y/z). After reset and after every write to one
//   of these registers the block re-derives eye point and view basis with an
//   iterative CORDIC (yaw then pitch) and one shared multiplier, during which
//   vertex_stall is held high. Vertex beats enter on vertex_valid &
//   !vertex_stall, one per cycle. Each beat gives one pixel beat; the
//   pipeline depth is set by the restoring divider, one quotient bit per
//   stage over FRAC_BITS+18 stages. Throughput is one vertex per cycle once
//   the basis is derived, while pixel_stall does not hold the pipeline.
//   When pixel_stall is high with a pixel waiting, the whole pipeline holds
//   and vertex_stall rises; nothing is dropped or repeated.
//   Reset clears all valid bits and reloads the camera defaults.
`timescale 1ns / 1ps
`default_nettype none

module vertex_view_project
    import vvp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        vertex_valid,
    output logic             vertex_stall,
    input  wire vertex_t     vertex,
    output logic             pixel_valid,
    input  wire logic        pixel_stall,
    output pixel_t           pixel
);

    localparam int QB = FRAC_BITS + 18;   // quotient bits kept
    localparam int DW = 40;               // view / divisor width
    localparam int NW = 67;               // 5 * |X| * zoom
    localparam int SW = QB + 3;

    localparam logic [30:0] DIST_RESET = 31'(64'd10 << FRAC_BITS);
    localparam logic [30:0] ZOOM_RESET = 31'(64'd50 << FRAC_BITS);
    localparam logic signed [DW-1:0] FOV_Q = DW'(64'(FOV_UNITS) << FRAC_BITS);
    localparam logic signed [SW-1:0] HALF_X_Q = SW'(64'(SCREEN_WIDTH / 2) << FRAC_BITS);
    localparam logic signed [SW-1:0] HALF_Y_Q = SW'(64'(SCREEN_HEIGHT / 2) << FRAC_BITS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_YAW   = 2'd1;
    localparam logic [1:0] ST_PITCH = 2'd2;
    localparam logic [1:0] ST_MUL   = 2'd3;

    // ---------------- configuration registers ----------------
    logic [15:0]        yaw_reg;
    logic [14:0]        pitch_reg;
    logic [30:0]        dist_reg;
    logic [30:0]        zoom_reg;
    logic signed [31:0] centre_x_reg, centre_y_reg, centre_z_reg;

    logic       cfg_wr;
    logic [2:0] wr_idx;
    logic       wr_known;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign wr_idx   = paddr[4:2];
    assign wr_known = cfg_wr && (wr_idx <= REG_CZ);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg      <= '0;
            pitch_reg    <= '0;
            dist_reg     <= DIST_RESET;
            zoom_reg     <= ZOOM_RESET;
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (wr_idx)
                REG_YAW:   yaw_reg      <= pwdata[15:0];
                REG_PITCH: pitch_reg    <= pwdata[14:0];
                REG_DIST:  dist_reg     <= pwdata[30:0];
                REG_ZOOM:  zoom_reg     <= pwdata[30:0];
                REG_CX:    centre_x_reg <= pwdata;
                REG_CY:    centre_y_reg <= pwdata;
                REG_CZ:    centre_z_reg <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_YAW:   prdata = {16'h0, yaw_reg};
            REG_PITCH: prdata = {17'h0, pitch_reg};
            REG_DIST:  prdata = {1'b0, dist_reg};
            REG_ZOOM:  prdata = {1'b0, zoom_reg};
            REG_CX:    prdata = centre_x_reg;
            REG_CY:    prdata = centre_y_reg;
            REG_CZ:    prdata = centre_z_reg;
            default:   prdata = '0;
        endcase
    end

    // ---------------- camera derivation sequencer ----------------
    logic [1:0]         state_reg;
    logic [4:0]         cnt_reg;
    logic signed [33:0] cor_x_reg, cor_y_reg, cor_z_reg;
    logic signed [33:0] ct_reg, st_reg, cp_reg, sp_reg, dcp_reg;
    logic signed [67:0] mul_reg;
    logic signed [31:0] eye_reg   [0:2];
    logic signed [31:0] basis_reg [0:8];

    logic signed [15:0] pitch_s, pitch_c;
    logic [31:0]        ang, ang_f;
    logic               flip;
    logic signed [33:0] cx, cy, cz, xs, ys, xn, yn, zn;
    logic               cor_last;
    logic signed [33:0] op_a, op_b, dist_s;
    logic [2:0]         mul_idx;
    logic signed [37:0] rr;
    logic               deriving;

    assign deriving = (state_reg != ST_IDLE);
    assign cor_last = (cnt_reg == 5'(CORDIC_STEPS - 1));
    assign mul_idx  = cnt_reg[3:1];
    assign dist_s   = {3'b000, dist_reg};
    assign rr       = rnd30(mul_reg);

    always_comb
    begin
        pitch_s = {pitch_reg[14], pitch_reg};
        if (pitch_s > PITCH_LIMIT)
            pitch_c = PITCH_LIMIT;
        else if (pitch_s < -PITCH_LIMIT)
            pitch_c = -PITCH_LIMIT;
        else
            pitch_c = pitch_s;
        ang   = (state_reg == ST_PITCH) ? {pitch_c, 16'h0} : {yaw_reg, 16'h0};
        // second and third quadrant: rotate by half a turn and negate the result
        flip  = ang[31] ^ ang[30];
        ang_f = flip ? (ang ^ 32'h80000000) : ang;
        cx    = (cnt_reg == '0) ? CORDIC_GAIN : cor_x_reg;
        cy    = (cnt_reg == '0) ? 34'sd0 : cor_y_reg;
        cz    = (cnt_reg == '0) ? {{2{ang_f[31]}}, ang_f} : cor_z_reg;
        xs    = cx >>> cnt_reg;
        ys    = cy >>> cnt_reg;
        if (!cz[33])
        begin
            xn = cx - ys;
            yn = cy + xs;
            zn = cz - atan_turn(cnt_reg);
        end
        else
        begin
            xn = cx + ys;
            yn = cy - xs;
            zn = cz + atan_turn(cnt_reg);
        end
    end

    always_comb
    begin
        unique case (mul_idx)
            3'd0:    begin op_a = dist_s;  op_b = cp_reg; end
            3'd1:    begin op_a = dcp_reg; op_b = st_reg; end
            3'd2:    begin op_a = dist_s;  op_b = sp_reg; end
            3'd3:    begin op_a = dcp_reg; op_b = ct_reg; end
            3'd4:    begin op_a = sp_reg;  op_b = st_reg; end
            3'd5:    begin op_a = sp_reg;  op_b = ct_reg; end
            3'd6:    begin op_a = cp_reg;  op_b = st_reg; end
            default: begin op_a = cp_reg;  op_b = ct_reg; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_YAW;
            cnt_reg   <= '0;
        end
        else if (wr_known)
        begin
            state_reg <= ST_YAW;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_YAW, ST_PITCH:
                begin
                    if (cor_last)
                    begin
                        state_reg <= (state_reg == ST_YAW) ? ST_PITCH : ST_MUL;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                ST_MUL:
                begin
                    if (cnt_reg == 5'd15)
                    begin
                        state_reg <= ST_IDLE;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                default: ;
            endcase
        end
    end

    // derivation datapath; even multiply steps issue, odd steps write back
    always_ff @(posedge clk)
    begin
        mul_reg   <= op_a * op_b;
        cor_x_reg <= xn;
        cor_y_reg <= yn;
        cor_z_reg <= zn;
        if (!wr_known && cor_last && state_reg == ST_YAW)
        begin
            ct_reg <= flip ? -xn : xn;
            st_reg <= flip ? -yn : yn;
        end
        if (!wr_known && cor_last && state_reg == ST_PITCH)
        begin
            cp_reg <= flip ? -xn : xn;
            sp_reg <= flip ? -yn : yn;
        end
        if (!wr_known && state_reg == ST_MUL && cnt_reg[0])
        begin
            case (mul_idx)
                3'd0:
                begin
                    dcp_reg      <= rr[33:0];
                    basis_reg[0] <= sat32(-{{6{ct_reg[33]}}, ct_reg});
                    basis_reg[1] <= '0;
                    basis_reg[2] <= sat32({{6{st_reg[33]}}, st_reg});
                    basis_reg[4] <= sat32({{6{cp_reg[33]}}, cp_reg});
                    basis_reg[7] <= sat32(-{{6{sp_reg[33]}}, sp_reg});
                end
                3'd1: eye_reg[0] <= sat32({{8{centre_x_reg[31]}}, centre_x_reg}
                                          + {{2{rr[37]}}, rr});
                3'd2: eye_reg[1] <= sat32({{8{centre_y_reg[31]}}, centre_y_reg}
                                          + {{2{rr[37]}}, rr});
                3'd3: eye_reg[2] <= sat32({{8{centre_z_reg[31]}}, centre_z_reg}
                                          + {{2{rr[37]}}, rr});
                3'd4: basis_reg[3] <= sat32(-{{2{rr[37]}}, rr});
                3'd5: basis_reg[5] <= sat32(-{{2{rr[37]}}, rr});
                3'd6: basis_reg[6] <= sat32(-{{2{rr[37]}}, rr});
                default: basis_reg[8] <= sat32(-{{2{rr[37]}}, rr});
            endcase
        end
    end

    // ---------------- vertex pipeline ----------------
    logic en, accept;
    logic out_valid_reg;
    pixel_t out_reg;

    assign en           = !out_valid_reg || !pixel_stall;
    assign vertex_stall = deriving || !en;
    assign accept       = vertex_valid && !vertex_stall;
    assign pixel_valid  = out_valid_reg;
    assign pixel        = out_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 1: offset by eye
    logic signed [32:0] pt_reg [0:2];
    // stage 2: rotation products
    logic signed [64:0] prod_reg [0:8];
    // stage 3: view coordinates
    logic signed [DW-1:0] view_reg [0:2];
    // stage 4: magnitudes and divisor
    logic [32:0]   mag_reg [0:1];
    logic          neg4_reg [0:1];
    logic [DW-1:0] den4_reg;
    logic          beh4_reg;
    // stage 5: products with zoom
    logic [63:0]   m_reg [0:1];
    logic          neg5_reg [0:1];
    logic [DW-1:0] den5_reg;
    logic          beh5_reg;

    // divider stages; index 0 is the setup stage
    logic [DW-1:0] dv_rem_reg [0:QB][0:1];
    logic [QB-1:0] dv_low_reg [0:QB][0:1];
    logic [QB-1:0] dv_q_reg   [0:QB][0:1];
    logic          dv_big_reg [0:QB][0:1];
    logic          dv_neg_reg [0:QB][0:1];
    logic [DW-1:0] dv_den_reg [0:QB];
    logic          dv_beh_reg [0:QB];
    logic          dv_v_reg   [0:QB];

    logic signed [DW-1:0] view_next [0:2];
    logic signed [DW-1:0] den_s;
    logic signed [DW-1:0] abs0, abs1;
    logic [NW-1:0]        n_next [0:1];
    logic [NW-1:0]        hi_next [0:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            dv_v_reg[0]   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            dv_v_reg[0]   <= v5_reg;
            out_valid_reg <= dv_v_reg[QB];
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            view_next[r] = DW'(rnd30({{3{prod_reg[3*r][64]}}, prod_reg[3*r]}))
                         + DW'(rnd30({{3{prod_reg[3*r+1][64]}}, prod_reg[3*r+1]}))
                         + DW'(rnd30({{3{prod_reg[3*r+2][64]}}, prod_reg[3*r+2]}));
        end
        den_s = view_reg[2] + FOV_Q;
        abs0  = view_reg[0][DW-1] ? -view_reg[0] : view_reg[0];
        abs1  = view_reg[1][DW-1] ? -view_reg[1] : view_reg[1];
        for (int a = 0; a < 2; a++)
        begin
            n_next[a]  = {1'b0, m_reg[a], 2'b00} + {3'b000, m_reg[a]};
            hi_next[a] = n_next[a] >> QB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg[0] <= 33'(vertex.vertex_x) - 33'(eye_reg[0]);
            pt_reg[1] <= 33'(vertex.vertex_y) - 33'(eye_reg[1]);
            pt_reg[2] <= 33'(vertex.vertex_z) - 33'(eye_reg[2]);

            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    prod_reg[3*r+k] <= pt_reg[k] * basis_reg[3*r+k];
            end

            for (int r = 0; r < 3; r++)
                view_reg[r] <= view_next[r];

            // screen y uses the negated view y
            neg4_reg[0] <= view_reg[0][DW-1];
            neg4_reg[1] <= !view_reg[1][DW-1] && (view_reg[1] != '0);
            mag_reg[0]  <= (abs0 > DW'(64'h1_FFFF_FFFF)) ? 33'h1_FFFF_FFFF : abs0[32:0];
            mag_reg[1]  <= (abs1 > DW'(64'h1_FFFF_FFFF)) ? 33'h1_FFFF_FFFF : abs1[32:0];
            den4_reg    <= den_s;
            beh4_reg    <= den_s[DW-1] || (den_s == '0);

            for (int a = 0; a < 2; a++)
            begin
                m_reg[a]    <= mag_reg[a] * zoom_reg;
                neg5_reg[a] <= neg4_reg[a];
            end
            den5_reg <= den4_reg;
            beh5_reg <= beh4_reg;

            // quotient that would not fit QB bits saturates the pixel anyway
            for (int a = 0; a < 2; a++)
            begin
                dv_big_reg[0][a] <= hi_next[a] >= NW'(den5_reg);
                dv_rem_reg[0][a] <= hi_next[a][DW-1:0];
                dv_low_reg[0][a] <= n_next[a][QB-1:0];
                dv_q_reg[0][a]   <= '0;
                dv_neg_reg[0][a] <= neg5_reg[a];
            end
            dv_den_reg[0] <= den5_reg;
            dv_beh_reg[0] <= beh5_reg;
        end
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j] <= 1'b0;
            else if (en)
                dv_v_reg[j] <= dv_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_den_reg[j] <= dv_den_reg[j-1];
                dv_beh_reg[j] <= dv_beh_reg[j-1];
            end
        end

        for (genvar a = 0; a < 2; a++)
        begin : g_lane
            logic [DW:0] sh;
            logic        ge;

            always_comb
            begin
                sh = {dv_rem_reg[j-1][a], dv_low_reg[j-1][a][QB-1]};
                ge = sh >= {1'b0, dv_den_reg[j-1]};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[j][a] <= ge ? DW'(sh - {1'b0, dv_den_reg[j-1]})
                                           : sh[DW-1:0];
                    dv_low_reg[j][a] <= {dv_low_reg[j-1][a][QB-2:0], 1'b0};
                    dv_q_reg[j][a]   <= {dv_q_reg[j-1][a][QB-2:0], ge};
                    dv_big_reg[j][a] <= dv_big_reg[j-1][a];
                    dv_neg_reg[j][a] <= dv_neg_reg[j-1][a];
                end
            end
        end
    end

    // final stage: sign, centre, truncate toward zero, clamp
    logic [QB:0]          fr   [0:1];
    logic signed [SW-1:0] fr_s [0:1];
    logic signed [SW-1:0] fsum [0:1];
    logic signed [SW-1:0] fmag [0:1];
    logic signed [SW-1:0] fpix [0:1];
    logic [15:0]          fclamp [0:1];
    logic                 fsat [0:1];
    pixel_t               out_next;

    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            fr[a]   = dv_big_reg[QB][a] ? ((QB+1)'(1) << QB) : {1'b0, dv_q_reg[QB][a]};
            fr_s[a] = {2'b00, fr[a]};
            fsum[a] = (dv_neg_reg[QB][a] ? -fr_s[a] : fr_s[a])
                    + ((a == 0) ? HALF_X_Q : HALF_Y_Q);
            fmag[a] = fsum[a][SW-1] ? -fsum[a] : fsum[a];
            fmag[a] = fmag[a] >>> FRAC_BITS;
            fpix[a] = fsum[a][SW-1] ? -fmag[a] : fmag[a];
            if (fpix[a] > SW'(32767))
            begin
                fclamp[a] = 16'h7FFF;
                fsat[a]   = 1'b1;
            end
            else if (fpix[a] < -SW'(32768))
            begin
                fclamp[a] = 16'h8000;
                fsat[a]   = 1'b1;
            end
            else
            begin
                fclamp[a] = fpix[a][15:0];
                fsat[a]   = 1'b0;
            end
        end
        if (dv_beh_reg[QB])
        begin
            out_next.screen_x        = '0;
            out_next.screen_y        = '0;
            out_next.behind_camera   = 1'b1;
            out_next.coord_saturated = 1'b0;
        end
        else
        begin
            out_next.screen_x        = fclamp[0];
            out_next.screen_y        = fclamp[1];
            out_next.behind_camera   = 1'b0;
            out_next.coord_saturated = fsat[0] || fsat[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

/* bench/tb_vertex_view_project.sv */
// Self-checking testbench for the orbit-camera view/projection block.
`timescale 1ns / 1ps

module tb_vertex_view_project;
    import vvp_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;  // unmapped register slot
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        vertex_valid;
    logic        vertex_stall;
    vertex_t     vertex;
    logic        pixel_valid;
    logic        pixel_stall;
    pixel_t      pixel;

    vertex_view_project dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
        .pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel)
    );

    // camera copy and derived view
    logic [31:0] cam_reg [0:6];
    longint      eye [0:2];
    longint      basis [0:8];

    pixel_t pending_pixels [$];
    int     errors;
    int     cycles;
    int     send_idle;
    int     recv_idle;
    int     vertices_sent;
    int     configs_done;
    bit     typed_valid;
    pixel_t typed_pixel;

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint tbl [0:19];
        tbl = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
                64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
                64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517};
        return tbl[i];
    endfunction

    // CORDIC rotation, angle at 2^32 per turn, results Q2.30
    task automatic cordic_rotate(input logic [31:0] ang, output longint c, output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
            ang = ang + 32'h80000000;
            flip = 1'b1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic derive_camera();
        longint pitch;
        longint ct;
        longint st;
        longint cp;
        longint sp;
        longint orbit_len;
        longint dcp;
        logic [31:0] pitch_ang;
        pitch = longint'($signed(cam_reg[REG_PITCH][14:0]));
        if (pitch > 15646)
            pitch = 15646;
        if (pitch < -15646)
            pitch = -15646;
        pitch_ang = {pitch[15:0], 16'h0000};
        cordic_rotate({cam_reg[REG_YAW][15:0], 16'h0000}, ct, st);
        cordic_rotate(pitch_ang, cp, sp);
        orbit_len = longint'(cam_reg[REG_DIST][30:0]);
        dcp = round_q30(orbit_len * cp);
        eye[0] = clip32(longint'($signed(cam_reg[REG_CX])) + round_q30(dcp * st));
        eye[1] = clip32(longint'($signed(cam_reg[REG_CY])) + round_q30(orbit_len * sp));
        eye[2] = clip32(longint'($signed(cam_reg[REG_CZ])) + round_q30(dcp * ct));
        basis[0] = clip32(-ct);
        basis[1] = 0;
        basis[2] = clip32(st);
        basis[3] = clip32(-round_q30(sp * st));
        basis[4] = clip32(cp);
        basis[5] = clip32(-round_q30(sp * ct));
        basis[6] = clip32(-round_q30(cp * st));
        basis[7] = clip32(-sp);
        basis[8] = clip32(-round_q30(cp * ct));
    endtask

    // one screen axis, saturated to 16 bits
    function automatic logic [15:0] screen_axis(longint v, longint den, longint half,
                                                ref bit clamped);
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned off;
        longint          sum;
        longint          pix;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        if (mag > ((64'd1 << 33) - 1))
            mag = (64'd1 << 33) - 1;
        prod = mag * longint'(cam_reg[REG_ZOOM][30:0]);
        quo = prod / den;
        rem = prod % den;
        if (quo >= (64'd1 << 58))
            off = 64'd1 << 60;
        else
            off = 5 * quo + (5 * rem) / den;
        sum = ((v < 0) ? -longint'(off) : longint'(off)) + (half <<< 16);
        pix = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);
        if (pix > 32767) begin
            pix = 32767;
            clamped = 1'b1;
        end
        if (pix < -32768) begin
            pix = -32768;
            clamped = 1'b1;
        end
        return pix[15:0];
    endfunction

    function automatic pixel_t project_vertex(vertex_t v);
        longint pt [0:2];
        longint vw [0:2];
        longint den;
        bit     clamped;
        pixel_t p;
        pt[0] = longint'(v.vertex_x) - eye[0];
        pt[1] = longint'(v.vertex_y) - eye[1];
        pt[2] = longint'(v.vertex_z) - eye[2];
        for (int r = 0; r < 3; r++) begin
            vw[r] = 0;
            for (int k = 0; k < 3; k++)
                vw[r] += round_q30(pt[k] * basis[r * 3 + k]);
        end
        den = (64'sd5 <<< 16) + vw[2];
        p = '0;
        clamped = 1'b0;
        if (den <= 0) begin
            p.behind_camera = 1'b1;
            return p;
        end
        p.screen_x = screen_axis(vw[0], den, 160, clamped);
        p.screen_y = screen_axis(-vw[1], den, 120, clamped);
        p.coord_saturated = clamped;
        return p;
    endfunction

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        pixel_t want;
        cycles <= cycles + 1;
        if (cycles > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycles, pending_pixels.size());
            $display("FAILURE");
            $finish;
        end
        if (rst_n && vertex_valid && !vertex_stall)
            pending_pixels.push_back(typed_valid ? typed_pixel : project_vertex(vertex));
        if (rst_n && pixel_valid && !pixel_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with nothing expected: %p", pixel);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (pixel.screen_x !== want.screen_x) begin
                    $error("screen_x expected %0d got %0d", want.screen_x, pixel.screen_x);
                    errors++;
                end
                if (pixel.screen_y !== want.screen_y) begin
                    $error("screen_y expected %0d got %0d", want.screen_y, pixel.screen_y);
                    errors++;
                end
                if (pixel.behind_camera !== want.behind_camera) begin
                    $error("behind_camera expected %0b got %0b",
                           want.behind_camera, pixel.behind_camera);
                    errors++;
                end
                if (pixel.coord_saturated !== want.coord_saturated) begin
                    $error("coord_saturated expected %0b got %0b",
                           want.coord_saturated, pixel.coord_saturated);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        pixel_stall <= rst_n && ($urandom_range(99) < recv_idle);

    task automatic send_vertex(vertex_t v);
        while ($urandom_range(99) < send_idle) begin
            vertex_valid = 1'b0;
            @(negedge clk);
        end
        vertex_valid = 1'b1;
        vertex = v;
        @(posedge clk);
        while (vertex_stall)
            @(posedge clk);
        @(negedge clk);
        vertices_sent++;
    endtask

    // block must be drained before a register write
    task automatic wait_drained();
        vertex_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_camera(logic [2:0] idx, logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx != REG_SPARE) begin
            cam_reg[idx] = value;
            derive_camera();
        end
        configs_done++;
    endtask

    function automatic logic [31:0] near_centre(logic [31:0] c, longint reach);
        longint off;
        off = $signed({$urandom, $urandom}) % (reach + 1);
        return 32'(clip32(longint'($signed(c)) + off));
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        longint  reach;
        if ($urandom_range(99) < 25) begin
            v.vertex_x = $urandom;
            v.vertex_y = $urandom;
            v.vertex_z = $urandom;
        end else begin
            reach = longint'(cam_reg[REG_DIST][30:0]) * 2 + (64'sd4 <<< 16);
            if ($urandom_range(3) == 0)
                reach = 64'sd2 <<< 16;
            v.vertex_x = near_centre(cam_reg[REG_CX], reach);
            v.vertex_y = near_centre(cam_reg[REG_CY], reach);
            v.vertex_z = near_centre(cam_reg[REG_CZ], reach);
        end
        return v;
    endfunction

    typedef struct {
        vertex_t v;
        bit      typed;
        pixel_t  want;
    } vertex_row_t;

    vertex_row_t directed [] = '{
        '{'{32'sd0, 32'sd0, 32'sh000A0000}, 1'b1, '{16'sd160, 16'sd120, 1'b0, 1'b0}},
        '{'{32'sd0, 32'sd0, 32'sh00640000}, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{'{32'sd0, 32'sd0, 32'sh000F0000}, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
        '{'{32'sh00010000, 32'sd0, 32'sh000EFFFF}, 1'b0, '0},
        '{'{32'shFFFF0000, 32'sh00010000, 32'sh000EFFFF}, 1'b0, '0},
        '{'{32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
        '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 1'b0, '0},
        '{'{32'sh7FFFFFFF, 32'sh80000000, 32'sd0}, 1'b0, '0},
        '{'{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000}, 1'b0, '0},
        '{'{32'sh00030000, 32'shFFFE0000, 32'sh00020000}, 1'b0, '0},
        '{'{32'shFFFFFFFF, 32'sd1, 32'sh00090000}, 1'b0, '0}
    };

    initial begin
        logic [31:0] setting [0:6];
        errors = 0;
        cycles = 0;
        vertices_sent = 0;
        configs_done = 0;
        send_idle = 12;
        recv_idle = 78;
        typed_valid = 1'b0;
        typed_pixel = '0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        vertex_valid = 1'b0;
        vertex = '0;
        pixel_stall = 1'b0;
        cam_reg[REG_YAW] = 32'd0;
        cam_reg[REG_PITCH] = 32'd0;
        cam_reg[REG_DIST] = 32'd655360;
        cam_reg[REG_ZOOM] = 32'd3276800;
        cam_reg[REG_CX] = 32'd0;
        cam_reg[REG_CY] = 32'd0;
        cam_reg[REG_CZ] = 32'd0;
        derive_camera();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i]) begin
            typed_valid = directed[i].typed;
            typed_pixel = directed[i].want;
            send_vertex(directed[i].v);
        end
        typed_valid = 1'b0;

        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 2) begin
                send_idle = 78;
                recv_idle = 12;
            end else if (phase == 4) begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (phase)
                0: setting = '{32'h0, 32'h0, 32'h000A0000, 32'h00320000, 32'h0, 32'h0, 32'h0};
                1: setting = '{32'h0000FFFF, 32'h00003FFF, 32'h0, 32'h7FFFFFFF,
                               32'h00010000, 32'hFFFF0000, 32'h00020000};
                // pitch below the clamp, far eye past the 32-bit range
                2: setting = '{32'h00004000, 32'hFFFFC000, 32'h7FFFFFFF, 32'h0,
                               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
                3: setting = '{32'h00008000, 32'h00003D1E, 32'h00050000, 32'h00000001,
                               32'h80000000, 32'h80000000, 32'h80000000};
                default: setting = '{$urandom, $urandom, $urandom_range(32'h00200000),
                                     $urandom_range(32'h01000000), $urandom_range(32'h00400000),
                                     $urandom_range(32'h00400000), $urandom};
            endcase
            wait_drained();
            for (int r = 0; r < 7; r++)
                write_camera(r[2:0], setting[r]);
            write_camera(REG_SPARE, $urandom);
            for (int n = 0; n < 185; n++)
                send_vertex(random_vertex());
        end

        vertex_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d vertices over %0d register writes in %0d cycles",
                 vertices_sent, configs_done, cycles);
        $display("camera extremes, pitch clamp, eye saturation, near-plane and behind-camera");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
